/* hdl/ckc_pkg.sv */
package ckc_pkg;

  // Built sizes
  localparam int MAX_K       = 10;
  localparam int COUNT_WIDTH = 16;
  localparam int WIN_BITS    = 2 * MAX_K;
  localparam int K_W         = $clog2(MAX_K + 1);
  localparam int SH_W        = K_W + 1;
  localparam int KLEN_W      = 4;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // Register map
  localparam int REG_IDX_W   = 1;
  localparam logic [REG_IDX_W-1:0] REG_KMER_LEN = 1'b0;
  localparam logic [KLEN_W-1:0]    KMER_LEN_RST = KLEN_W'(MAX_K);

  // Base codes
  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  typedef logic [WIN_BITS-1:0]    kmer_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  // Front to queue push
  typedef struct packed {
    logic  valid;
    kmer_t idx;
  } kmer_push_t;

  // Queue head seen by the back end
  typedef struct packed {
    logic  valid;
    kmer_t idx;
  } kmer_head_t;

  // Back end result word
  typedef struct packed {
    logic   saturated;
    count_t new_count;
    kmer_t  kmer_index;
  } kmer_result_t;

  function automatic logic [1:0] base_code(input logic [7:0] c);
    logic [1:0] code;
    unique case (c)
      8'h43:   code = CODE_C;
      8'h47:   code = CODE_G;
      8'h54:   code = CODE_T;
      default: code = CODE_A;
    endcase
    return code;
  endfunction

endpackage

/* hdl/canonical_kmer_counter.sv */
// Canonical k-mer counter. Takes one ASCII DNA base per word (A/C/G/T, any
// other byte counts as A) with tuser marking the first base of a read, and
// for every position where kmer_len bases of the read are in hand emits the
// canonical k-mer (smaller of forward and reverse complement) together with
// its 16-bit count after the increment; counters stick at 65535 and flag
// saturated. Sustained rate is one base per clock while m_tready stays high:
// the front end updates the windows and picks the canonical index in the
// accept cycle, a 4-word queue decouples it from the back end, and the back
// end does the table read-modify-write as a registered read, then add and
// write, with forwarding of the previous write, so repeated k-mers do not
// stall. An accepted base reaches m_tvalid through the queue slot, the table
// read register and the output register. After reset the 1,048,576-entry
// table is zeroed one entry per cycle while s_tready stays low; kmer_len can
// be written during that time. kmer_len 0 acts as 1, values above 10 act as 10.
module canonical_kmer_counter (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] base_char
  input  logic        s_tuser,   // [0] read_start
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [19:0] kmer_index, [35:20] new_count, [36] saturated
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ckc_pkg::*;

  logic [KLEN_W-1:0]     kmer_len;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  accept, q_full, pop, busy;
  kmer_push_t            push;
  kmer_head_t            head;
  kmer_result_t          out_word;

  // register port: one word, no wait states
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign prdata  = (reg_idx == REG_KMER_LEN) ? {{(32-KLEN_W){1'b0}}, kmer_len} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len <= KMER_LEN_RST;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_KMER_LEN)) begin
      kmer_len <= pwdata[KLEN_W-1:0];
    end
  end

  // no input while the table is being cleared or the queue is full
  assign s_tready = !busy && !q_full;
  assign accept   = s_tvalid && s_tready;

  ckc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .base_char  (s_tdata),
    .read_start (s_tuser),
    .kmer_len   (kmer_len),
    .push       (push)
  );

  ckc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  ckc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .busy      (busy),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (out_word)
  );

  assign m_tdata = {3'b000, out_word};

endmodule

/* hdl/ckc_front.sv */
module ckc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                base_char,
  input  logic                      read_start,
  input  logic [ckc_pkg::KLEN_W-1:0] kmer_len,
  output ckc_pkg::kmer_push_t       push
);
  import ckc_pkg::*;

  localparam logic [K_W-1:0] MAX_K_V  = K_W'(MAX_K);
  localparam kmer_t          WIN_ONES = '1;

  kmer_t          fw;
  kmer_t          rc;
  logic [K_W-1:0] nbases;

  kmer_t          fw_base, rc_base, fw_next, rc_next, fw_k, rc_k;
  logic [K_W-1:0] nbases_base, nbases_next, k_eff;
  logic [SH_W-1:0] shamt;
  logic [1:0]     b;

  always_comb begin
    priority if (kmer_len == '0) begin
      k_eff = K_W'(1);
    end else if (kmer_len > KLEN_W'(MAX_K)) begin
      k_eff = MAX_K_V;
    end else begin
      k_eff = K_W'(kmer_len);
    end
  end

  always_comb begin
    b           = base_code(base_char);
    fw_base     = read_start ? '0 : fw;
    rc_base     = read_start ? '0 : rc;
    nbases_base = read_start ? '0 : nbases;
    fw_next     = {fw_base[WIN_BITS-3:0], b};
    rc_next     = {~b, rc_base[WIN_BITS-1:2]};   // complement 3-b is ~b
    nbases_next = (nbases_base < MAX_K_V) ? nbases_base + K_W'(1) : nbases_base;
    shamt       = {MAX_K_V - k_eff, 1'b0};
    fw_k        = fw_next & (WIN_ONES >> shamt);
    rc_k        = rc_next >> shamt;
  end

  assign push.valid = accept && (nbases_next >= k_eff);
  assign push.idx   = (fw_k <= rc_k) ? fw_k : rc_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      fw     <= '0;
      rc     <= '0;
      nbases <= '0;
    end else if (accept) begin
      fw     <= fw_next;
      rc     <= rc_next;
      nbases <= nbases_next;
    end
  end

endmodule

/* hdl/ckc_queue.sv */
module ckc_queue (
  input  logic                clk,
  input  logic                rst,
  input  ckc_pkg::kmer_push_t push,
  input  logic                pop,
  output ckc_pkg::kmer_head_t head,
  output logic                full
);
  import ckc_pkg::*;

  kmer_t              slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_pop;

  assign head.valid = (count != '0);
  assign head.idx   = slots[rd_ptr];
  assign full       = (count == QCNT_W'(QDEPTH));
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push.valid, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/ckc_back.sv */
module ckc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  ckc_pkg::kmer_head_t   head,
  output logic                  pop,
  output logic                  busy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ckc_pkg::kmer_result_t out_word
);
  import ckc_pkg::*;

  localparam count_t COUNT_MAX = '1;
  localparam kmer_t  LAST_ADDR = '1;

  count_t mem [0:(1 << WIN_BITS)-1];

  // clearing pass
  logic   clr_active;
  kmer_t  clr_addr;

  // lookup stage
  logic   d_valid;
  kmer_t  d_addr;
  count_t rd_data;

  // last write, for read-during-write forwarding
  logic   fwd_valid;
  kmer_t  fwd_addr;
  count_t fwd_data;

  logic   adv, sat, we;
  count_t old, cnt, wd;
  kmer_t  wa;

  assign busy = clr_active;
  assign adv  = !d_valid || !out_valid || out_ready;
  assign pop  = adv && head.valid && !clr_active;

  always_comb begin
    old = (fwd_valid && (fwd_addr == d_addr)) ? fwd_data : rd_data;
    sat = (old == COUNT_MAX);
    cnt = sat ? old : old + COUNT_WIDTH'(1);
    we  = clr_active || (adv && d_valid);
    wa  = clr_active ? clr_addr : d_addr;
    wd  = clr_active ? '0 : cnt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (pop) begin
      rd_data <= mem[head.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_addr   <= head.idx;
      fwd_addr <= d_addr;
      fwd_data <= cnt;
    end
    if (adv && d_valid) begin
      out_word.kmer_index <= d_addr;
      out_word.new_count  <= cnt;
      out_word.saturated  <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
      d_valid    <= 1'b0;
      fwd_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + WIN_BITS'(1);
        if (clr_addr == LAST_ADDR) begin
          clr_active <= 1'b0;
        end
      end
      if (adv) begin
        d_valid   <= pop;
        fwd_valid <= d_valid;
      end
      if (adv && d_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/ckc_checker.sv */
module ckc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // clearing pass holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[36] |-> m_tdata[35:20] == 16'hFFFF)
    else $error("saturated with count below max");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[35:20] != 16'h0000)
    else $error("result with zero count");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:37] == 3'b000)
    else $error("padding bits set");

endmodule

bind canonical_kmer_counter ckc_checker u_ckc_checker (.*);

/* verif/canonical_kmer_counter_tb.sv */
`timescale 1ns / 1ps

module canonical_kmer_counter_tb;
  import ckc_pkg::*;

  // Longest legal stretch without any word moving is the table clear after
  // reset (one entry per clock); the limit below is a multiple of that.
  localparam int unsigned CLEAR_CYCLES = 1 << WIN_BITS;
  localparam int unsigned STALL_LIMIT  = 3 * CLEAR_CYCLES;
  localparam int unsigned HOLD_CYCLES  = 300;   // one long back-pressure stretch
  localparam int unsigned SETTLE_GAP   = 12;    // outlasts the pipeline and queue

  typedef struct packed {
    logic [7:0] base_char;
    logic       read_start;
  } base_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;      // [7:0] base_char
  logic        s_tuser = 1'b0;    // [0] read_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // [19:0] kmer_index, [35:20] new_count, [36] saturated
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  canonical_kmer_counter u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow of the counter: windows, base count, kmer_len and the table.
  // The table is sparse here; a missing entry reads as zero (cleared).
  // ---------------------------------------------------------------------
  logic [KLEN_W-1:0] klen_cfg = KMER_LEN_RST;
  kmer_t             fwd_win = '0;
  kmer_t             rc_win = '0;
  int unsigned       bases_held = 0;
  count_t            tally [kmer_t];
  kmer_result_t      expected_counts [$];
  base_word_t        base_feed [$];

  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  logic        s_took = 1'b0;     // a base word went in at the last rising edge
  logic        no_gaps = 1'b0;    // both sides stream without idling
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  // Update the shadow for one accepted base and queue the count it yields.
  function automatic void count_base(input base_word_t w);
    logic [1:0]   code;
    int unsigned  k;
    kmer_t        mask, fw, rc, idx;
    count_t       old;
    kmer_result_t r;
    case (w.base_char)
      "C":     code = CODE_C;
      "G":     code = CODE_G;
      "T":     code = CODE_T;
      default: code = CODE_A;   // N, lowercase and every other byte
    endcase
    // Register out of range is clamped to 1..MAX_K
    k = (klen_cfg == 0) ? 1 : (klen_cfg > MAX_K) ? MAX_K : klen_cfg;
    if (w.read_start) begin
      fwd_win    = '0;
      rc_win     = '0;
      bases_held = 0;
    end
    // Forward: newest code low; reverse complement: newest complement high
    fwd_win = {fwd_win[WIN_BITS-3:0], code};
    rc_win  = {2'd3 - code, rc_win[WIN_BITS-1:2]};
    if (bases_held < MAX_K) bases_held++;
    if (bases_held < k) return;   // read still too short
    mask = kmer_t'((64'd1 << (2 * k)) - 1);
    fw   = fwd_win & mask;
    rc   = (rc_win >> (2 * (MAX_K - k))) & mask;
    idx  = (fw <= rc) ? fw : rc;
    old  = tally.exists(idx) ? tally[idx] : '0;
    r.kmer_index = idx;
    r.saturated  = (old == '1);
    r.new_count  = r.saturated ? old : old + 1'b1;
    tally[idx]   = r.new_count;
    expected_counts = {expected_counts, r};
  endfunction

  task automatic log_miss(input string what, input logic [39:0] want, input logic [39:0] got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------
  // Input driver: changes at the falling edge, holds a word until taken.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    base_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_took || !s_tvalid) begin
      if (base_feed.size() != 0 && (no_gaps || $urandom_range(99) >= 30)) begin
        w = base_feed.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= w.base_char;
        s_tuser  <= w.read_start;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output side ready: random gaps, plus one long hold once results flow,
  // long enough that the internal queue fills and s_tready drops.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (!hold_done && results_seen >= 60) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= no_gaps || ($urandom_range(99) >= 30);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predicts on every accepted base word, checks every result
  // word against the oldest expected count.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    kmer_result_t want, got;
    if (rst) begin
      s_took <= 1'b0;
    end else begin
      s_took <= s_tvalid && s_tready;
      if (s_tvalid && s_tready)
        count_base('{base_char: s_tdata, read_start: s_tuser});
      if (m_tvalid && m_tready) begin
        results_seen++;
        got = kmer_result_t'(m_tdata[36:0]);
        if (expected_counts.size() == 0) begin
          log_miss("unexpected word", '0, m_tdata);
        end else begin
          want = expected_counts.pop_front();
          if (got.kmer_index !== want.kmer_index)
            log_miss("kmer_index", 40'(want.kmer_index), 40'(got.kmer_index));
          if (got.new_count !== want.new_count)
            log_miss("new_count", 40'(want.new_count), 40'(got.new_count));
          if (got.saturated !== want.saturated)
            log_miss("saturated", 40'(want.saturated), 40'(got.saturated));
        end
      end
    end
  end

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic push_base(input logic [7:0] c, input logic rs);
    base_feed = {base_feed, base_word_t'{base_char: c, read_start: rs}};
  endtask

  // Mostly clean A/C/G/T, sometimes any byte at all
  function automatic logic [7:0] pick_base();
    if ($urandom_range(9) == 0) return 8'($urandom());
    case ($urandom_range(3))
      0:       return "A";
      1:       return "C";
      2:       return "G";
      default: return "T";
    endcase
  endfunction

  task automatic push_string(input string s, input logic fresh);
    for (int i = 0; i < s.len(); i++)
      push_base(s[i], fresh && i == 0);
  endtask

  // Two-phase register write; the shadow follows at the write edge
  task automatic write_kmer_len(input logic [3:0] k);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_KMER_LEN, 2'b00};
    pwdata  <= ($urandom() & 32'hFFFF_FFF0) | 32'(k);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    klen_cfg = k;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait for every base taken and every count returned, then let the
  // pipeline empty of bases that produce nothing.
  task automatic settle();
    while (base_feed.size() != 0 || s_tvalid || expected_counts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  initial begin
    logic [3:0]  k_plan [8] = '{4'd1, 4'd10, 4'd2, 4'd15, 4'd3, 4'd0, 4'd6, 4'd4};
    int unsigned n_phase;
    int unsigned len;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset kmer_len of 10. First read has no start flag; N, NUL, 0xFF and
    // lowercase all count as A. Then a short read and an all-T read.
    push_base("A", 1'b0);
    push_base("C", 1'b0);
    push_base("G", 1'b0);
    push_base("T", 1'b0);
    push_base("N", 1'b0);
    push_base(8'h00, 1'b0);
    push_base(8'hFF, 1'b0);
    push_base("a", 1'b0);
    push_string("CGTA", 1'b0);
    push_string("GATTC", 1'b1);
    push_string("TTTTTTTTTT", 1'b1);
    settle();

    // kmer_len 0 acts as 1; read carries over from the previous setting
    write_kmer_len(4'd0);
    push_string("ACGT", 1'b0);
    push_base(8'h80, 1'b0);
    settle();

    // Above MAX_K acts as MAX_K; window is already full
    write_kmer_len(4'd15);
    push_string("GGC", 1'b0);
    settle();

    // k of 1 and only A-like or T bases: every word lands on k-mer 0
    write_kmer_len(4'd1);
    push_base("A", 1'b1);
    for (int i = 0; i < 23; i++)
      push_base(($urandom_range(2) == 0) ? "T" : (($urandom_range(1) == 0) ? "A" : "N"), 1'b0);
    settle();

    // Random phases over the full range of kmer_len, half of them starting
    // in the middle of the previous read. One phase streams without gaps.
    foreach (k_plan[p]) begin
      write_kmer_len((p == 7) ? 4'($urandom_range(15)) : k_plan[p]);
      no_gaps = (p == 4);
      n_phase = 0;
      while (n_phase < 130) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 24);
        for (int i = 0; i < len; i++)
          push_base(pick_base(), (i == 0) && (n_phase != 0 || $urandom_range(1) == 1));
        n_phase += len;
      end
      settle();
    end
    no_gaps = 1'b0;

    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
hdl/ckc_pkg.sv
hdl/ckc_front.sv
hdl/ckc_queue.sv
hdl/ckc_back.sv
hdl/canonical_kmer_counter.sv
hdl/ckc_checker.sv
verif/canonical_kmer_counter_tb.sv
